/* src/bpa_pkg.sv */
// Shared constants and codes for the buddy page allocator.
package bpa_pkg;

	// Free-map memory word: one bit per page, sixteen pages per word.
	localparam int WORD_BITS = 16;
	localparam int WORD_SH   = 4;

	localparam int ORDER_IN_W  = 3;
	localparam int COUNT_OUT_W = 11;
	localparam int COUNT_SAT   = 2047;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

endpackage

/* src/bpa_map_mem.sv */
// Free-block bitmap memory: one write port, one read port, registered read data.
module bpa_map_mem
	import bpa_pkg::*;
#(
	parameter int AW = 9
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [2**AW];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/bpa_word_unit.sv */
// Shared word unit: page-range mask, hit test and lowest set bit of one map word.
module bpa_word_unit
	import bpa_pkg::*;
#(
	parameter int PX = 10,
	parameter int OW = 3
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [PX-1:0]        wbase,
	input  logic [PX:0]          lo,
	input  logic [PX:0]          hi,
	input  logic [OW-1:0]        stride,
	output logic [WORD_BITS-1:0] mask,
	output logic                 hit,
	output logic [WORD_SH-1:0]   first
);

	logic [PX:0]          amask;
	logic [WORD_BITS-1:0] sel;

	assign amask = ~({(PX+1){1'b1}} << stride);

	always_comb begin
		logic [PX:0] pg;
		for (int i = 0; i < WORD_BITS; i++) begin
			pg = {1'b0, wbase} + (PX+1)'(i);
			mask[i] = (pg >= lo) && (pg < hi) && ((pg & amask) == '0);
		end
	end

	assign sel = word & mask;
	assign hit = |sel;

	always_comb begin
		first = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				first = WORD_SH'(i);
			end
		end
	end

endmodule

/* src/buddy_page_allocator.sv */
// Buddy page allocator: sequencer, free counters, free-map memory and word unit.
// An allocate searches the orders for a free block, scans map words for it and writes
// the map words that it splits; a free checks map words for overlap, takes merge steps
// and sets the block; a final step delivers the result.
// One item at a time; the map memory's single read port sets pace. After reset a clearing
// pass writes every map word before the first item is accepted.
module buddy_page_allocator
	import bpa_pkg::*;
#(
	parameter int PAGES  = 1024,
	parameter int ORDERS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [ORDER_IN_W-1:0]     block_order,
	input  logic [$clog2(PAGES)-1:0]  page_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [$clog2(PAGES)-1:0]  granted_page,
	output logic                      status,
	output logic [COUNT_OUT_W-1:0]    free_blocks
);

	localparam int PW = $clog2(PAGES);
	localparam int PX = (PW > WORD_SH + 1) ? PW : WORD_SH + 1;
	localparam int WB = PX - WORD_SH;
	localparam int OW = $clog2(ORDERS);
	localparam int AW = OW + WB;
	localparam int CW = $clog2(PAGES + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ASRCH, S_SCAN_RD, S_SCAN_CHK, S_SPL_RD, S_SPL_WR,
		S_OV_SET, S_OV_RD, S_OV_CHK, S_MRG_SET, S_MRG_RD, S_MRG_CHK,
		S_SET_RD, S_SET_WR, S_DONE
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic                 bad_q;
	logic [OW-1:0]        ord_q;
	logic [OW-1:0]        k_q;
	logic [OW-1:0]        j_q;
	logic [PX:0]          base_q;
	logic [PX:0]          lo_q;
	logic [PX:0]          hi_q;
	logic [WB-1:0]        w_q;
	logic [WB-1:0]        wend_q;
	logic [CW-1:0]        cnt_q [ORDERS];
	logic [PX:0]          grant_q;
	logic                 stat_q;
	logic                 ov_q;
	logic [PW-1:0]        gout_q;
	logic                 sout_q;
	logic [COUNT_OUT_W-1:0] fout_q;

	logic                 we, re;
	logic [AW-1:0]        waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;
	logic [WORD_BITS-1:0] u_mask;
	logic                 u_hit;
	logic [WORD_SH-1:0]   u_first;
	logic [OW-1:0]        u_stride;

	bpa_map_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	bpa_word_unit #(.PX(PX), .OW(OW)) u_unit (
		.word(rdata), .wbase({w_q, {WORD_SH{1'b0}}}), .lo(lo_q), .hi(hi_q),
		.stride(u_stride), .mask(u_mask), .hit(u_hit), .first(u_first)
	);

	assign u_stride = (state_q == S_SPL_WR) ? ord_q : '0;

	always_comb begin
		we = 1'b0;
		waddr = {k_q, w_q};
		wdata = '0;
		re = 1'b0;
		raddr = {k_q, w_q};
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			S_SCAN_RD, S_MRG_RD, S_SET_RD: re = 1'b1;
			S_SPL_RD: begin
				re = 1'b1;
				raddr = {ord_q, w_q};
			end
			S_OV_RD: begin
				re = 1'b1;
				raddr = {j_q, w_q};
			end
			S_SCAN_CHK: begin
				we = u_hit;
				wdata = rdata & ~(WORD_BITS'(1) << u_first);
			end
			S_SPL_WR: begin
				we = 1'b1;
				waddr = {ord_q, w_q};
				wdata = rdata | u_mask;
			end
			S_MRG_CHK: begin
				we = u_hit;
				wdata = rdata & ~u_mask;
			end
			S_SET_WR: begin
				we = 1'b1;
				wdata = rdata | u_mask;
			end
			default: ;
		endcase
	end

	function automatic logic [PX:0] size_of(input logic [OW-1:0] k);
		return (PX+1)'(1) << k;
	endfunction

	logic [PX:0]   in_sz, in_base, scan_base, k_sz, buddy, j_lo, ov_lo, ov_hi, spl_hi;
	logic [OW-1:0] in_ord, diff;
	logic [CW-1:0] split_add;
	logic          in_bad;

	assign in_ord   = OW'(block_order);
	assign in_bad   = (int'(block_order) >= ORDERS);
	assign in_sz    = size_of(in_ord);
	assign in_base  = (PX+1)'(page_index) & ~(in_sz - (PX+1)'(1));
	assign scan_base = {1'b0, w_q, u_first};
	assign k_sz     = size_of(k_q);
	assign buddy    = base_q ^ k_sz;
	assign spl_hi   = scan_base + k_sz - size_of(ord_q);
	assign diff     = k_q - ord_q;
	assign split_add = (CW'(1) << diff) - CW'(1);
	assign j_lo     = base_q & ~(size_of(j_q) - (PX+1)'(1));
	assign ov_lo    = (j_q <= ord_q) ? base_q : j_lo;
	assign ov_hi    = (j_q <= ord_q) ? base_q + size_of(ord_q) : j_lo + (PX+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < ORDERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						ord_q <= in_ord;
						k_q <= in_ord;
						j_q <= '0;
						base_q <= in_base;
						bad_q <= in_bad;
						grant_q <= '0;
						stat_q <= (in_bad && func == FUNC_ALLOC) ? STATUS_OOM : STATUS_OK;
						if (in_bad) begin
							state_q <= S_DONE;
						end else if (func == FUNC_ALLOC) begin
							state_q <= S_ASRCH;
						end else if (in_base + in_sz > (PX+1)'(PAGES)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_OV_SET;
						end
					end
				end
				S_ASRCH: begin
					if (cnt_q[k_q] != '0) begin
						w_q <= '0;
						lo_q <= '0;
						hi_q <= '1;
						state_q <= S_SCAN_RD;
					end else if (int'(k_q) == ORDERS - 1) begin
						stat_q <= STATUS_OOM;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + OW'(1);
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (u_hit) begin
						cnt_q[k_q] <= cnt_q[k_q] - CW'(1);
						if (k_q == ord_q) begin
							grant_q <= scan_base;
							state_q <= S_DONE;
						end else begin
							// Every piece but the highest goes back as free.
							cnt_q[ord_q] <= cnt_q[ord_q] + split_add;
							grant_q <= spl_hi;
							lo_q <= scan_base;
							hi_q <= spl_hi;
							w_q <= scan_base[PX-1:WORD_SH];
							wend_q <= WB'((spl_hi - (PX+1)'(1)) >> WORD_SH);
							state_q <= S_SPL_RD;
						end
					end else begin
						w_q <= w_q + WB'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SPL_RD: state_q <= S_SPL_WR;
				S_SPL_WR: begin
					if (w_q == wend_q) begin
						state_q <= S_DONE;
					end else begin
						w_q <= w_q + WB'(1);
						state_q <= S_SPL_RD;
					end
				end
				S_OV_SET: begin
					lo_q <= ov_lo;
					hi_q <= ov_hi;
					w_q <= ov_lo[PX-1:WORD_SH];
					wend_q <= WB'((ov_hi - (PX+1)'(1)) >> WORD_SH);
					state_q <= S_OV_RD;
				end
				S_OV_RD: state_q <= S_OV_CHK;
				S_OV_CHK: begin
					if (u_hit) begin
						state_q <= S_DONE;
					end else if (w_q != wend_q) begin
						w_q <= w_q + WB'(1);
						state_q <= S_OV_RD;
					end else if (int'(j_q) == ORDERS - 1) begin
						state_q <= S_MRG_SET;
					end else begin
						j_q <= j_q + OW'(1);
						state_q <= S_OV_SET;
					end
				end
				S_MRG_SET: begin
					if (int'(k_q) == ORDERS - 1 || buddy + k_sz > (PX+1)'(PAGES)) begin
						lo_q <= base_q;
						hi_q <= base_q + (PX+1)'(1);
						w_q <= base_q[PX-1:WORD_SH];
						state_q <= S_SET_RD;
					end else begin
						lo_q <= buddy;
						hi_q <= buddy + (PX+1)'(1);
						w_q <= buddy[PX-1:WORD_SH];
						state_q <= S_MRG_RD;
					end
				end
				S_MRG_RD: state_q <= S_MRG_CHK;
				S_MRG_CHK: begin
					if (u_hit) begin
						cnt_q[k_q] <= cnt_q[k_q] - CW'(1);
						base_q <= base_q & ~k_sz;
						k_q <= k_q + OW'(1);
						state_q <= S_MRG_SET;
					end else begin
						lo_q <= base_q;
						hi_q <= base_q + (PX+1)'(1);
						w_q <= base_q[PX-1:WORD_SH];
						state_q <= S_SET_RD;
					end
				end
				S_SET_RD: state_q <= S_SET_WR;
				S_SET_WR: begin
					cnt_q[k_q] <= cnt_q[k_q] + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || out_ready) begin
						ov_q <= 1'b1;
						gout_q <= (stat_q == STATUS_OOM) ? '0 : PW'(grant_q);
						sout_q <= stat_q;
						if (bad_q) begin
							fout_q <= '0;
						end else if (int'(cnt_q[ord_q]) >= COUNT_SAT) begin
							fout_q <= COUNT_OUT_W'(COUNT_SAT);
						end else begin
							fout_q <= COUNT_OUT_W'(cnt_q[ord_q]);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = ov_q;
	assign granted_page = gout_q;
	assign status       = sout_q;
	assign free_blocks  = fout_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("allocator accepted a second item without finishing the first");

	a_oom_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OOM |-> granted_page == '0)
		else $error("failed allocation reported a page");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE || state_q == S_DONE |-> !we)
		else $error("map written outside an operation");

endmodule
